/* rtl/core/ttyld_pkg.sv */
`default_nettype none

package ttyld_pkg;

  localparam int unsigned RING_DEPTH  = 128;
  localparam int unsigned CHANNELS    = 2;
  localparam int unsigned SLOT_W      = $clog2(RING_DEPTH);
  localparam int unsigned PTR_W       = SLOT_W + 1;
  localparam int unsigned CH_W        = 1;
  localparam int unsigned ADDR_W      = CH_W + SLOT_W;
  localparam int unsigned STORE_DEPTH = CHANNELS * RING_DEPTH;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_LF     = 8'h0a;
  localparam logic [7:0] KEY_CR     = 8'h0d;
  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_DEL    = 8'h7f;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CANON_SERIAL,
    CFG_ECHO_SERIAL,
    CFG_CANON_CONSOLE,
    CFG_ECHO_CONSOLE
  } cfg_idx_e;

  typedef enum logic {
    OP_RECEIVE,
    OP_READ
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic       wr;
    logic [7:0] wr_char;
    ptr_t       edit_nxt;
    ptr_t       commit_nxt;
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       proc_list;
  } rx_edit_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       end_of_file;
    logic       buffer_empty;
    logic       stop_read;
    logic       proc_list;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/ttyld_line_store.sv */
`default_nettype none

module ttyld_line_store (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [ttyld_pkg::ADDR_W-1:0] waddr_i,
  input  wire logic [7:0]                 wdata_i,
  input  wire logic                       re_i,
  input  wire logic [ttyld_pkg::ADDR_W-1:0] raddr_i,
  output logic      [7:0]                 rdata_o
);
  import ttyld_pkg::*;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/ttyld_rx_edit.sv */
`default_nettype none

module ttyld_rx_edit (
  input  wire logic                canon_i,
  input  wire logic                echo_i,
  input  wire logic [7:0]          char_i,
  input  wire ttyld_pkg::ptr_t     read_ptr_i,
  input  wire ttyld_pkg::ptr_t     commit_ptr_i,
  input  wire ttyld_pkg::ptr_t     edit_ptr_i,
  output ttyld_pkg::rx_edit_t      edit_o
);
  import ttyld_pkg::*;

  ptr_t       used;
  ptr_t       line_len;
  ptr_t       edit_inc;
  ptr_t       used_inc;
  logic       room;
  logic [7:0] stored;

  always_comb begin
    used     = edit_ptr_i - read_ptr_i;
    line_len = edit_ptr_i - commit_ptr_i;
    edit_inc = edit_ptr_i + PTR_W'(1);
    used_inc = edit_inc - read_ptr_i;
    room     = (32'(used) < RING_DEPTH);
    stored   = (canon_i && char_i == KEY_CR) ? KEY_LF : char_i;

    edit_o            = '0;
    edit_o.edit_nxt   = edit_ptr_i;
    edit_o.commit_nxt = commit_ptr_i;

    if (canon_i && char_i == KEY_CTRL_P) begin
      edit_o.proc_list = 1'b1;
    end else if (canon_i && char_i == KEY_CTRL_U) begin
      edit_o.edit_nxt = commit_ptr_i;
      if (echo_i) begin
        edit_o.erase_count = (32'(line_len) > 32'd255) ? 8'hff : 8'(line_len);
      end
    end else if (canon_i && (char_i == KEY_CTRL_H || char_i == KEY_DEL)) begin
      if (edit_ptr_i != commit_ptr_i) begin
        edit_o.edit_nxt = edit_ptr_i - PTR_W'(1);
        if (echo_i) begin
          edit_o.erase_count = 8'd1;
        end
      end
    end else if (char_i != KEY_NUL && room) begin
      edit_o.wr       = 1'b1;
      edit_o.wr_char  = stored;
      edit_o.edit_nxt = edit_inc;
      if (echo_i && stored != KEY_CTRL_D) begin
        edit_o.echo_valid = 1'b1;
        edit_o.echo_char  = stored;
      end
      if (!canon_i || stored == KEY_LF || stored == KEY_CTRL_D ||
          32'(used_inc) == RING_DEPTH) begin
        edit_o.commit_nxt = edit_inc;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tty_line_discipline_buffer.sv */
// Terminal input buffer with one ring per channel. An item is taken when start_i is
// high and busy_o is low, and its single result is shown for exactly one cycle with
// done_o high; the receiver cannot stall, so results must be taken as they appear.
// A receive item, a read of an empty buffer and an item for a channel without a ring
// give their result the cycle after the transfer, and busy_o stays low. A read that
// finds committed data reads the line store, whose output is registered, in ST_READ;
// busy_o is high for one cycle in that state and the result is registered after it.
// Configuration writes are taken at any edge with cfg_we_i high but must only be
// issued while no item is in flight.
`default_nettype none

module tty_line_discipline_buffer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          op_i,
  input  wire logic                          channel_i,
  input  wire logic [7:0]                    char_in_i,
  input  wire logic                          first_of_read_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [ttyld_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic                          cfg_wdata_i,
  output logic                               done_o,
  output logic                               echo_valid_o,
  output logic      [7:0]                    echo_char_o,
  output logic      [7:0]                    erase_count_o,
  output logic                               data_valid_o,
  output logic      [7:0]                    data_byte_o,
  output logic                               end_of_file_o,
  output logic                               buffer_empty_o,
  output logic                               stop_read_o,
  output logic                               process_list_request_o
);
  import ttyld_pkg::*;

  state_e     state_q, state_d;
  ptr_t       rp_q [CHANNELS];
  ptr_t       rp_d [CHANNELS];
  ptr_t       cp_q [CHANNELS];
  ptr_t       cp_d [CHANNELS];
  ptr_t       ep_q [CHANNELS];
  ptr_t       ep_d [CHANNELS];
  logic [1:0] canon_q;
  logic [1:0] echo_q;
  logic       ch_q, ch_d;
  logic       first_q, first_d;
  logic       done_q, done_d;
  result_t    res_q, res_d;

  logic                accept;
  logic                ch_ok;
  logic                canon_in;
  logic                echo_in;
  logic                canon_rd;
  rx_edit_t            rx;
  logic                mem_we;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [7:0]          mem_rdata;

  assign busy_o   = (state_q == ST_READ);
  assign accept   = start_i && !busy_o;
  assign ch_ok    = (32'(channel_i) < CHANNELS);
  assign canon_in = channel_i ? canon_q[1] : canon_q[0];
  assign echo_in  = channel_i ? echo_q[1] : echo_q[0];
  assign canon_rd = ch_q ? canon_q[1] : canon_q[0];

  ttyld_rx_edit u_rx_edit (
    .canon_i      (canon_in),
    .echo_i       (echo_in),
    .char_i       (char_in_i),
    .read_ptr_i   (rp_q[channel_i]),
    .commit_ptr_i (cp_q[channel_i]),
    .edit_ptr_i   (ep_q[channel_i]),
    .edit_o       (rx)
  );

  assign mem_waddr = {channel_i, ep_q[channel_i][SLOT_W-1:0]};
  assign mem_raddr = {channel_i, rp_q[channel_i][SLOT_W-1:0]};

  ttyld_line_store u_line_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (rx.wr_char),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canon_q <= 2'b11;
      echo_q  <= 2'b11;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CANON_SERIAL:  canon_q[0] <= cfg_wdata_i;
        CFG_ECHO_SERIAL:   echo_q[0]  <= cfg_wdata_i;
        CFG_CANON_CONSOLE: canon_q[1] <= cfg_wdata_i;
        CFG_ECHO_CONSOLE:  echo_q[1]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        rp_q[i] <= '0;
        cp_q[i] <= '0;
        ep_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      rp_q    <= rp_d;
      cp_q    <= cp_d;
      ep_q    <= ep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    ch_q    <= ch_d;
    first_q <= first_d;
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    res_d   = '0;
    rp_d    = rp_q;
    cp_d    = cp_q;
    ep_d    = ep_q;
    ch_d    = ch_q;
    first_d = first_q;
    mem_we  = 1'b0;
    mem_re  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ch_d    = channel_i;
          first_d = first_of_read_i;
          if (!ch_ok) begin
            done_d = 1'b1;
          end else if (op_e'(op_i) == OP_RECEIVE) begin
            done_d            = 1'b1;
            mem_we            = rx.wr;
            ep_d[channel_i]   = rx.edit_nxt;
            cp_d[channel_i]   = rx.commit_nxt;
            res_d.echo_valid  = rx.echo_valid;
            res_d.echo_char   = rx.echo_char;
            res_d.erase_count = rx.erase_count;
            res_d.proc_list   = rx.proc_list;
          end else if (rp_q[channel_i] == cp_q[channel_i]) begin
            done_d             = 1'b1;
            res_d.buffer_empty = 1'b1;
          end else begin
            mem_re  = 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (canon_rd && mem_rdata == KEY_CTRL_D) begin
          res_d.end_of_file = 1'b1;
          if (first_q) begin
            rp_d[ch_q] = rp_q[ch_q] + PTR_W'(1);
          end
        end else begin
          rp_d[ch_q]       = rp_q[ch_q] + PTR_W'(1);
          res_d.data_valid = 1'b1;
          res_d.data_byte  = mem_rdata;
          res_d.stop_read  = (mem_rdata == KEY_LF) || !canon_rd;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign done_o                 = done_q;
  assign echo_valid_o           = res_q.echo_valid;
  assign echo_char_o            = res_q.echo_char;
  assign erase_count_o          = res_q.erase_count;
  assign data_valid_o           = res_q.data_valid;
  assign data_byte_o            = res_q.data_byte;
  assign end_of_file_o          = res_q.end_of_file;
  assign buffer_empty_o         = res_q.buffer_empty;
  assign stop_read_o            = res_q.stop_read;
  assign process_list_request_o = res_q.proc_list;

endmodule

`default_nettype wire

/* rtl/core/ttyld_checker.sv */
`default_nettype none

module ttyld_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_i,
  input wire logic       done_i,
  input wire logic       echo_valid_i,
  input wire logic [7:0] erase_count_i,
  input wire logic       data_valid_i,
  input wire logic       end_of_file_i,
  input wire logic       buffer_empty_i,
  input wire logic       stop_read_i,
  input wire logic       process_list_request_i
);

  // every transfer is answered next cycle or holds the block busy
  a_transfer_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> done_i || busy_i)
    else $error("transfer neither answered nor busy");

  // a busy cycle is single and ends in a result
  a_busy_ends_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i |=> !busy_i && done_i)
    else $error("busy not followed by result");

  // no result without a transfer or a busy cycle before it
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(start_i && !busy_i) || $past(busy_i))
    else $error("result without a transfer");

  // a result carries at most one kind of outcome
  a_outcome_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $countones({echo_valid_i, (erase_count_i != 8'd0), data_valid_i,
                           end_of_file_i, buffer_empty_i, process_list_request_i}) <= 1)
    else $error("more than one outcome in a result");

  // stop only comes with returned data
  a_stop_with_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && stop_read_i |-> data_valid_i)
    else $error("stop_read without data");

endmodule

bind tty_line_discipline_buffer ttyld_checker u_ttyld_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .start_i                (start_i),
  .busy_i                 (busy_o),
  .done_i                 (done_o),
  .echo_valid_i           (echo_valid_o),
  .erase_count_i          (erase_count_o),
  .data_valid_i           (data_valid_o),
  .end_of_file_i          (end_of_file_o),
  .buffer_empty_i         (buffer_empty_o),
  .stop_read_i            (stop_read_o),
  .process_list_request_i (process_list_request_o)
);

`default_nettype wire

/* tb/ttyld_result_checker.sv */
module ttyld_result_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic                           busy_i,
  input  wire logic                           op_i,
  input  wire logic                           channel_i,
  input  wire logic [7:0]                     char_in_i,
  input  wire logic                           first_of_read_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [ttyld_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic                           cfg_wdata_i,
  input  wire logic                           done_i,
  input  wire logic                           echo_valid_i,
  input  wire logic [7:0]                     echo_char_i,
  input  wire logic [7:0]                     erase_count_i,
  input  wire logic                           data_valid_i,
  input  wire logic [7:0]                     data_byte_i,
  input  wire logic                           end_of_file_i,
  input  wire logic                           buffer_empty_i,
  input  wire logic                           stop_read_i,
  input  wire logic                           process_list_request_i,
  output int                                  pending_o,
  output int                                  errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ttyld_pkg::*;

  result_t    awaited_results[$];
  logic [7:0] ring_mem [CHANNELS][RING_DEPTH];
  ptr_t       rd_ptr [CHANNELS];
  ptr_t       cm_ptr [CHANNELS];
  ptr_t       ed_ptr [CHANNELS];
  logic       canon_q [CHANNELS];
  logic       echo_q [CHANNELS];
  int         errors;

  function automatic string show(result_t r);
    return $sformatf("echo=%0d/%h erase=%0d data=%0d/%h eof=%0d empty=%0d stop=%0d plist=%0d",
                     r.echo_valid, r.echo_char, r.erase_count, r.data_valid, r.data_byte,
                     r.end_of_file, r.buffer_empty, r.stop_read, r.proc_list);
  endfunction

  function automatic result_t edit_line(op_e op, logic ch, logic [7:0] c, logic first);
    result_t    r;
    logic [7:0] b;
    ptr_t       used;
    r = '0;
    if (op == OP_RECEIVE) begin
      used = ed_ptr[ch] - rd_ptr[ch];
      if (canon_q[ch] && c == KEY_CTRL_P) begin
        r.proc_list = 1'b1;
      end else if (canon_q[ch] && c == KEY_CTRL_U) begin
        if (echo_q[ch]) r.erase_count = ed_ptr[ch] - cm_ptr[ch];
        ed_ptr[ch] = cm_ptr[ch];
      end else if (canon_q[ch] && (c == KEY_CTRL_H || c == KEY_DEL)) begin
        if (ed_ptr[ch] != cm_ptr[ch]) begin
          ed_ptr[ch] = ed_ptr[ch] - 1'b1;
          if (echo_q[ch]) r.erase_count = 8'd1;
        end
      end else if (c != KEY_NUL && used < RING_DEPTH) begin
        if (canon_q[ch] && c == KEY_CR) c = KEY_LF;
        ring_mem[ch][ed_ptr[ch][SLOT_W-1:0]] = c;
        ed_ptr[ch] = ed_ptr[ch] + 1'b1;
        if (echo_q[ch] && c != KEY_CTRL_D) begin
          r.echo_valid = 1'b1;
          r.echo_char  = c;
        end
        used = ed_ptr[ch] - rd_ptr[ch];
        if (!canon_q[ch] || c == KEY_LF || c == KEY_CTRL_D || used == RING_DEPTH)
          cm_ptr[ch] = ed_ptr[ch];
      end
    end else begin
      if (rd_ptr[ch] == cm_ptr[ch]) begin
        r.buffer_empty = 1'b1;
      end else begin
        b = ring_mem[ch][rd_ptr[ch][SLOT_W-1:0]];
        if (canon_q[ch] && b == KEY_CTRL_D) begin
          r.end_of_file = 1'b1;
          if (first) rd_ptr[ch] = rd_ptr[ch] + 1'b1;
        end else begin
          rd_ptr[ch]  = rd_ptr[ch] + 1'b1;
          r.data_valid = 1'b1;
          r.data_byte  = b;
          r.stop_read  = (b == KEY_LF) || !canon_q[ch];
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rd_ptr[i]  = '0;
        cm_ptr[i]  = '0;
        ed_ptr[i]  = '0;
        canon_q[i] = 1'b1;
        echo_q[i]  = 1'b1;
      end
      awaited_results.delete();
      errors = 0;
    end else begin
      if (done_i) begin
        seen.echo_valid   = echo_valid_i;
        seen.echo_char    = echo_char_i;
        seen.erase_count  = erase_count_i;
        seen.data_valid   = data_valid_i;
        seen.data_byte    = data_byte_i;
        seen.end_of_file  = end_of_file_i;
        seen.buffer_empty = buffer_empty_i;
        seen.stop_read    = stop_read_i;
        seen.proc_list    = process_list_request_i;
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: unexpected result %s", $realtime, show(seen));
        end else begin
          want = awaited_results.pop_front();
          if (seen !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(seen));
            end
          end
        end
      end
      if (start_i && !busy_i)
        awaited_results.push_back(edit_line(op_e'(op_i), channel_i, char_in_i,
                                            first_of_read_i));
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CANON_SERIAL:  canon_q[0] = cfg_wdata_i;
          CFG_ECHO_SERIAL:   echo_q[0]  = cfg_wdata_i;
          CFG_CANON_CONSOLE: canon_q[1] = cfg_wdata_i;
          CFG_ECHO_CONSOLE:  echo_q[1]  = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pending_o <= awaited_results.size();
    errors_o  <= errors;
  end

endmodule

/* tb/tty_line_discipline_buffer_tb.sv */
module tty_line_discipline_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ttyld_pkg::*;

  localparam int IdleLimit    = 1000;
  localparam int PhaseCount   = 8;
  localparam int RandomBudget = 85;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic                 op_i;
  logic                 channel_i;
  logic [7:0]           char_in_i;
  logic                 first_of_read_i;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic                 cfg_wdata_i;
  logic                 done_o;
  logic                 echo_valid_o;
  logic [7:0]           echo_char_o;
  logic [7:0]           erase_count_o;
  logic                 data_valid_o;
  logic [7:0]           data_byte_o;
  logic                 end_of_file_o;
  logic                 buffer_empty_o;
  logic                 stop_read_o;
  logic                 process_list_request_o;
  int                   pending;
  int                   errors;
  int                   sent;
  int                   idle_cycles;
  bit                   calm;

  tty_line_discipline_buffer i_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .start_i                (start_i),
    .busy_o                 (busy_o),
    .op_i                   (op_i),
    .channel_i              (channel_i),
    .char_in_i              (char_in_i),
    .first_of_read_i        (first_of_read_i),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .done_o                 (done_o),
    .echo_valid_o           (echo_valid_o),
    .echo_char_o            (echo_char_o),
    .erase_count_o          (erase_count_o),
    .data_valid_o           (data_valid_o),
    .data_byte_o            (data_byte_o),
    .end_of_file_o          (end_of_file_o),
    .buffer_empty_o         (buffer_empty_o),
    .stop_read_o            (stop_read_o),
    .process_list_request_o (process_list_request_o)
  );

  ttyld_result_checker i_checker (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .start_i                (start_i),
    .busy_i                 (busy_o),
    .op_i                   (op_i),
    .channel_i              (channel_i),
    .char_in_i              (char_in_i),
    .first_of_read_i        (first_of_read_i),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .done_i                 (done_o),
    .echo_valid_i           (echo_valid_o),
    .echo_char_i            (echo_char_o),
    .erase_count_i          (erase_count_o),
    .data_valid_i           (data_valid_o),
    .data_byte_i            (data_byte_o),
    .end_of_file_i          (end_of_file_o),
    .buffer_empty_i         (buffer_empty_o),
    .stop_read_i            (stop_read_o),
    .process_list_request_i (process_list_request_o),
    .pending_o              (pending),
    .errors_o               (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((start_i && !busy_o) || done_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic rest(input int cycles);
    start_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic send_item(input op_e op, input logic ch, input logic [7:0] c,
                           input logic first);
    start_i         = 1'b1;
    op_i            = op;
    channel_i       = ch;
    char_in_i       = c;
    first_of_read_i = first;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
    if (!calm && $urandom_range(0, 7) == 0) rest($urandom_range(1, 17));
  endtask

  task automatic drain();
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_modes(input logic [3:0] modes);
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    = 1'b1;
      cfg_idx_i   = i[CFG_IDX_W-1:0];
      cfg_wdata_i = modes[i];
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(8'h20, 8'h7e));
    if (r < 74) return KEY_CTRL_H;
    if (r < 77) return KEY_DEL;
    if (r < 79) return KEY_CTRL_U;
    if (r < 81) return KEY_CTRL_P;
    if (r < 83) return KEY_NUL;
    return 8'($urandom);
  endfunction

  task automatic fill_ring(input logic ch);
    repeat (RING_DEPTH + 4) send_item(OP_RECEIVE, ch, 8'($urandom_range(8'h21, 8'h7e)), 1'b0);
    send_item(OP_RECEIVE, ch, KEY_CTRL_H, 1'b0);
    repeat (RING_DEPTH + 8) send_item(OP_READ, ch, 8'($urandom), 1'b1);
  endtask

  task automatic typed_line();
    logic       ch;
    int         len;
    int         term;
    logic [7:0] ends [4];
    ends = '{KEY_CR, KEY_LF, KEY_CTRL_D, KEY_CR};
    ch   = 1'($urandom_range(0, 1));
    len  = $urandom_range(0, 12);
    repeat (len) send_item(OP_RECEIVE, ch, pick_char(), 1'($urandom_range(0, 1)));
    term = $urandom_range(0, 4);
    if (term < 4) send_item(OP_RECEIVE, ch, ends[term], 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, len + 3))
      send_item(OP_READ, ch, 8'($urandom), 1'($urandom_range(0, 3) != 0));
  endtask

  initial begin
    logic [3:0] modes;
    int         budget;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    op_i            = OP_RECEIVE;
    channel_i       = 1'b0;
    char_in_i       = '0;
    first_of_read_i = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = 1'b0;
    sent            = 0;
    calm            = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < PhaseCount; p++) begin
      if (p == 0 || p == 2) modes = 4'b1111;
      else if (p == 1) modes = 4'b0000;
      else modes = 4'($urandom);
      calm = (p == PhaseCount - 1);
      write_modes(modes);

      if (p == 0) begin
        send_item(OP_READ, 1'b0, 8'h00, 1'b1);
        send_item(OP_RECEIVE, 1'b0, 8'h61, 1'b0);
        send_item(OP_RECEIVE, 1'b0, 8'hff, 1'b1);
        send_item(OP_RECEIVE, 1'b0, 8'h01, 1'b0);
        send_item(OP_RECEIVE, 1'b0, KEY_CR, 1'b0);
        repeat (4) send_item(OP_READ, 1'b0, 8'hff, 1'b1);
        send_item(OP_RECEIVE, 1'b0, KEY_NUL, 1'b0);
        send_item(OP_RECEIVE, 1'b0, KEY_CTRL_P, 1'b0);
        send_item(OP_RECEIVE, 1'b1, 8'h78, 1'b0);
        send_item(OP_RECEIVE, 1'b1, 8'h79, 1'b0);
        send_item(OP_RECEIVE, 1'b1, KEY_CTRL_H, 1'b0);
        send_item(OP_RECEIVE, 1'b1, KEY_DEL, 1'b0);
        send_item(OP_RECEIVE, 1'b1, KEY_DEL, 1'b0);
        send_item(OP_RECEIVE, 1'b1, 8'h7a, 1'b0);
        send_item(OP_RECEIVE, 1'b1, KEY_CTRL_U, 1'b0);
        send_item(OP_RECEIVE, 1'b1, KEY_CTRL_U, 1'b0);
        send_item(OP_RECEIVE, 1'b1, KEY_CTRL_D, 1'b0);
        send_item(OP_READ, 1'b1, 8'h00, 1'b0);
        send_item(OP_READ, 1'b1, 8'h00, 1'b1);
        send_item(OP_READ, 1'b1, 8'h00, 1'b1);
        send_item(OP_RECEIVE, 1'b0, 8'h80, 1'b0);
        send_item(OP_RECEIVE, 1'b0, KEY_LF, 1'b0);
        repeat (2) send_item(OP_READ, 1'b0, 8'h00, 1'b0);
      end
      if (p == 1) fill_ring(1'b0);
      if (p == 2) fill_ring(1'b1);

      budget = sent + RandomBudget;
      while (sent < budget) begin
        if ($urandom_range(0, 9) < 6) begin
          typed_line();
        end else begin
          send_item(op_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'($urandom),
                    1'($urandom_range(0, 1)));
        end
      end
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
